/* hw/rtl/mfpd_pkg.sv */
// Shared types and constants for the framed packet deframer.
// Used by the frame parser, the top level and the testbench.
package mfpd_pkg;

    localparam logic [31:0] HEAD_WORD = 32'h6865_6164;
    localparam logic [31:0] TAIL_WORD = 32'h7461_696c;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1012;
    localparam logic [15:0] TAIL_BYTES = 16'd4;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHK_HI = 3'd4,
        PH_CHK_LO = 3'd5,
        PH_TAIL   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        EV_BYTE     = 3'd0,
        EV_OK       = 3'd1,
        EV_CHECK    = 3'd2,
        EV_TAIL     = 3'd3,
        EV_OVERSIZE = 3'd4
    } event_t;

    typedef struct packed {
        logic        emit;
        event_t      ev;
        logic [7:0]  data;
        logic [15:0] len;
    } result_t;

endpackage

/* hw/rtl/mfpd_in_if.sv */
// Input byte channel of the deframer.
// Carries one received byte per transfer; no dependencies.
interface mfpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

/* hw/rtl/mfpd_out_if.sv */
// Result channel of the deframer.
// Carries one event with its byte and frame length per transfer.
interface mfpd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  out_byte;
    logic [15:0] frame_len;

    modport source (output valid, output event_res, output out_byte, output frame_len,
                    input ready);
    modport sink (input valid, input event_res, input out_byte, input frame_len,
                  output ready);
endinterface

/* hw/rtl/mfpd_cfg_if.sv */
// Configuration write channel of the deframer.
// Carries the maximum payload length register value per transfer.
interface mfpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_payload;

    modport source (output valid, output max_payload, input ready);
    modport sink (input valid, input max_payload, output ready);
endinterface

/* hw/rtl/mfpd_parser.sv */
// Frame parser: holds the hunt, length, count, check and tail state and
// computes one byte's result. Depends on mfpd_pkg.
module mfpd_parser
    import mfpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data,
    input  logic [15:0] max_payload,
    output result_t     result
);

    phase_t      phase_reg, phase_next;
    logic [31:0] hunt_reg, hunt_next;
    logic [31:0] tail_reg, tail_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] check_reg, check_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            hunt_reg  <= '0;
            tail_reg  <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            check_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hunt_reg  <= hunt_next;
            tail_reg  <= tail_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            check_reg <= check_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hunt_next   = hunt_reg;
        tail_next   = tail_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        check_next  = check_reg;
        result.emit = 1'b0;
        result.ev   = EV_BYTE;
        result.data = '0;
        case (phase_reg)
            PH_LEN_HI:
            begin
                len_next   = {data, 8'h00};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next = {len_reg[15:8], data};
                if (len_next > max_payload)
                begin
                    hunt_next   = '0;
                    tail_next   = '0;
                    count_next  = '0;
                    phase_next  = PH_HUNT;
                    result.emit = 1'b1;
                    result.ev   = EV_OVERSIZE;
                end
                else
                begin
                    count_next = '0;
                    phase_next = (len_next == 16'd0) ? PH_CHK_HI : PH_DATA;
                end
            end
            PH_DATA:
            begin
                count_next = count_reg + 16'd1;
                if (count_next >= len_reg)
                begin
                    phase_next = PH_CHK_HI;
                end
                result.emit = 1'b1;
                result.ev   = EV_BYTE;
                result.data = data;
            end
            PH_CHK_HI:
            begin
                check_next = {data, 8'h00};
                phase_next = PH_CHK_LO;
            end
            PH_CHK_LO:
            begin
                check_next = {check_reg[15:8], data};
                tail_next  = '0;
                count_next = '0;
                phase_next = PH_TAIL;
            end
            PH_TAIL:
            begin
                tail_next  = {tail_reg[23:0], data};
                count_next = count_reg + 16'd1;
                if (count_next >= TAIL_BYTES)
                begin
                    result.emit = 1'b1;
                    if (tail_next != TAIL_WORD)
                    begin
                        result.ev = EV_TAIL;
                    end
                    else if (check_reg != 16'd0)
                    begin
                        result.ev = EV_CHECK;
                    end
                    else
                    begin
                        result.ev = EV_OK;
                    end
                    hunt_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                hunt_next  = {hunt_reg[23:0], data};
                phase_next = (hunt_next == HEAD_WORD) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
        result.len = len_next;
    end

endmodule

/* hw/rtl/magic_framed_packet_deframer.sv */
// Top level of the framed packet deframer: input register, frame parser,
// result register and the maximum payload register. Depends on mfpd_pkg,
// the three channel interfaces and mfpd_parser.

// The block takes at most one received byte per cycle and finds frames made of the
// start word "head", a 16-bit big-endian length, the payload, a 16-bit check
// word that must be zero and the end word "tail". Each payload byte is given
// out as event 0; at the end of a frame one status transfer reports ok, check
// error or bad tail, and a length above max_payload gives an oversize event
// right after the second length byte. A byte passes an input register and
// one stage of parser logic into the result register, from which its result
// is offered; a new byte is taken in every cycle while the result side keeps
// up, and there is no buffer beyond the input and result registers, so a
// stalled result holds back further input once the input register is full.
module magic_framed_packet_deframer
    import mfpd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    mfpd_in_if.sink   rx,
    mfpd_out_if.source tx,
    mfpd_cfg_if.sink  cfg
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    event_t      out_event_reg;
    logic [7:0]  out_byte_reg;
    logic [15:0] out_len_reg;
    logic [15:0] max_payload_reg;
    logic        advance;
    logic        step;
    result_t     result;

    assign advance  = !out_valid_reg || tx.ready;
    assign step     = in_valid_reg && advance;
    assign rx.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign tx.valid     = out_valid_reg;
    assign tx.event_res = out_event_reg;
    assign tx.out_byte  = out_byte_reg;
    assign tx.frame_len = out_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg.valid)
        begin
            max_payload_reg <= cfg.max_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.in_byte;
        end
    end

    mfpd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data        (in_byte_reg),
        .max_payload (max_payload_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.emit)
        begin
            out_event_reg <= result.ev;
            out_byte_reg  <= result.data;
            out_len_reg   <= result.len;
        end
    end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the framed packet deframer: a directed table of bytes and
// random framed byte streams, every result compared against a parser model or the table.
// Depends on mfpd_pkg, the three channel interfaces and magic_framed_packet_deframer.
module testbench;
    import mfpd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned LONG_HOLD = 400;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PHASE_ITEMS = 200;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int DIRECTED_COUNT = 31;
    localparam int SETTING_COUNT = 6;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  data;
        logic [15:0] len;
    } frame_result_t;

    typedef struct packed {
        logic          pinned;
        frame_result_t res;
    } pinned_result_t;

    typedef struct packed {
        logic [7:0]    b;
        logic          pinned;
        frame_result_t res;
    } directed_row_t;

    localparam frame_result_t NO_RESULT = '{EV_BYTE, 8'h00, 16'h0000};

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'h68, 1'b0, NO_RESULT},
        '{8'h65, 1'b0, NO_RESULT},
        '{8'h61, 1'b0, NO_RESULT},
        '{8'h64, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h74, 1'b0, NO_RESULT},
        '{8'h61, 1'b0, NO_RESULT},
        '{8'h69, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{EV_TAIL, 8'h00, 16'd0}},
        '{8'h68, 1'b0, NO_RESULT},
        '{8'h65, 1'b0, NO_RESULT},
        '{8'h61, 1'b0, NO_RESULT},
        '{8'h64, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, '{EV_OVERSIZE, 8'h00, 16'hFFFF}},
        '{8'h68, 1'b0, NO_RESULT},
        '{8'h65, 1'b0, NO_RESULT},
        '{8'h61, 1'b0, NO_RESULT},
        '{8'h64, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, '{EV_BYTE, 8'hFF, 16'd1}},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h74, 1'b0, NO_RESULT},
        '{8'h61, 1'b0, NO_RESULT},
        '{8'h69, 1'b0, NO_RESULT},
        '{8'h6C, 1'b1, '{EV_OK, 8'h00, 16'd1}}
    };

    logic clk;
    logic rst_n;

    mfpd_in_if  rx_if ();
    mfpd_out_if tx_if ();
    mfpd_cfg_if cfg_if ();

    magic_framed_packet_deframer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if),
        .cfg   (cfg_if)
    );

    logic [31:0]    hunt_reg = '0;
    phase_t         parse_phase = PH_HUNT;
    logic [15:0]    frame_length = '0;
    logic [15:0]    byte_index = '0;
    logic [15:0]    check_value = '0;
    logic [31:0]    tail_reg = '0;
    logic [15:0]    max_len = MAX_PAYLOAD_RESET;

    frame_result_t  pending_results [$];
    pinned_result_t pinned_results [$];
    logic [15:0]    gen_limit = MAX_PAYLOAD_RESET;
    int unsigned    items_sent = 0;
    int             failures = 0;
    bit             steady = 1'b0;
    bit             long_hold_req = 1'b0;
    bit             hold_asked = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void restart_hunt();
        hunt_reg = '0;
        tail_reg = '0;
        byte_index = '0;
        parse_phase = PH_HUNT;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t res);
        bit has;
        has = 1'b0;
        res = NO_RESULT;
        case (parse_phase)
            PH_LEN_HI:
            begin
                frame_length = {b, 8'h00};
                parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                frame_length = {frame_length[15:8], b};
                if (frame_length > max_len)
                begin
                    res = '{EV_OVERSIZE, 8'h00, frame_length};
                    has = 1'b1;
                    restart_hunt();
                end
                else
                begin
                    byte_index = '0;
                    parse_phase = (frame_length == 16'd0) ? PH_CHK_HI : PH_DATA;
                end
            end
            PH_DATA:
            begin
                byte_index = byte_index + 16'd1;
                if (byte_index >= frame_length)
                    parse_phase = PH_CHK_HI;
                res = '{EV_BYTE, b, frame_length};
                has = 1'b1;
            end
            PH_CHK_HI:
            begin
                check_value = {b, 8'h00};
                parse_phase = PH_CHK_LO;
            end
            PH_CHK_LO:
            begin
                check_value = {check_value[15:8], b};
                tail_reg = '0;
                byte_index = '0;
                parse_phase = PH_TAIL;
            end
            PH_TAIL:
            begin
                tail_reg = {tail_reg[23:0], b};
                byte_index = byte_index + 16'd1;
                if (byte_index >= TAIL_BYTES)
                begin
                    if (tail_reg != TAIL_WORD)
                        res.ev = EV_TAIL;
                    else if (check_value != 16'd0)
                        res.ev = EV_CHECK;
                    else
                        res.ev = EV_OK;
                    res.len = frame_length;
                    has = 1'b1;
                    restart_hunt();
                end
            end
            default:
            begin
                hunt_reg = {hunt_reg[23:0], b};
                parse_phase = (hunt_reg == HEAD_WORD) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
        return has;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        rx_if.valid <= 1'b1;
        rx_if.in_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        items_sent++;
        gap = pick_gap();
        if (gap != 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stop_sending();
        rx_if.valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_payload(input logic [15:0] value);
        wait_for_drain();
        gen_limit = value;
        cfg_if.valid <= 1'b1;
        cfg_if.max_payload <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_random_frame();
        int unsigned kind;
        int unsigned pick;
        int          cap;
        int          cut;
        int          spot;
        logic [15:0] flen;
        logic [15:0] chk;
        logic [7:0]  body [$];
        steady = ($urandom_range(0, 7) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 6)
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        for (int k = 0; k < 4; k++)
            send_byte(HEAD_WORD[31 - 8 * k -: 8]);
        if (kind < 16 && gen_limit != 16'hFFFF)
        begin
            flen = 16'($urandom_range(int'(gen_limit) + 1, 65535));
            send_byte(flen[15:8]);
            send_byte(flen[7:0]);
            return;
        end
        pick = $urandom_range(0, 99);
        cap = (pick < 70) ? 12 : ((pick < 95) ? 64 : 300);
        if (cap > int'(gen_limit))
            cap = int'(gen_limit);
        flen = 16'($urandom_range(0, cap));
        if (pick >= 98)
            flen = 16'(cap);
        send_byte(flen[15:8]);
        send_byte(flen[7:0]);
        for (int k = 0; k < int'(flen); k++)
            body.push_back(8'($urandom_range(0, 255)));
        if (flen >= 16'd4 && $urandom_range(0, 7) == 0)
        begin
            spot = $urandom_range(0, int'(flen) - 4);
            for (int k = 0; k < 4; k++)
                body[spot + k] = HEAD_WORD[31 - 8 * k -: 8];
        end
        chk = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) : 16'h0000;
        body.push_back(chk[15:8]);
        body.push_back(chk[7:0]);
        for (int k = 0; k < 4; k++)
            body.push_back(TAIL_WORD[31 - 8 * k -: 8]);
        if ($urandom_range(0, 5) == 0)
        begin
            spot = int'(flen) + 2 + $urandom_range(0, 3);
            body[spot] = body[spot] ^ 8'($urandom_range(1, 255));
        end
        cut = (kind < 21) ? $urandom_range(0, body.size() - 1) : body.size();
        for (int k = 0; k < cut; k++)
            send_byte(body[k]);
    endtask

    always @(posedge clk)
    begin : byte_tracker
        frame_result_t  res;
        pinned_result_t pin;
        bit             has;
        if (rst_n && rx_if.valid && rx_if.ready)
        begin
            has = deframe_byte(rx_if.in_byte, res);
            if (pinned_results.size() != 0)
            begin
                pin = pinned_results.pop_front();
                if (pin.pinned)
                begin
                    has = 1'b1;
                    res = pin.res;
                end
            end
            if (has)
                pending_results.push_back(res);
        end
        if (rst_n && cfg_if.valid && cfg_if.ready)
            max_len = cfg_if.max_payload;
    end

    always @(posedge clk)
    begin : result_checker
        frame_result_t want;
        if (rst_n && tx_if.valid && tx_if.ready)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result: ev=%0d byte=%02h len=%0d",
                    tx_if.event_res, tx_if.out_byte, tx_if.frame_len));
            else
            begin
                want = pending_results.pop_front();
                if (tx_if.event_res !== want.ev || tx_if.out_byte !== want.data ||
                    tx_if.frame_len !== want.len)
                    note_failure($sformatf(
                        "result mismatch: expected ev=%0d byte=%02h len=%0d, got ev=%0d byte=%02h len=%0d",
                        want.ev, want.data, want.len,
                        tx_if.event_res, tx_if.out_byte, tx_if.frame_len));
            end
        end
    end

    initial
    begin : result_sink
        int unsigned gap;
        tx_if.ready = 1'b0;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                tx_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                tx_if.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                gap = pick_gap();
                if (gap != 0)
                begin
                    tx_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] settings [SETTING_COUNT];
        rst_n = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.in_byte = 8'h00;
        cfg_if.valid = 1'b0;
        cfg_if.max_payload = 16'h0000;
        settings[0] = 16'd0;
        settings[1] = 16'hFFFF;
        settings[2] = 16'($urandom_range(1, 40));
        settings[3] = 16'($urandom_range(0, 65535));
        settings[4] = MAX_PAYLOAD_RESET;
        settings[5] = 16'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            pinned_results.push_back('{DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].res});
            send_byte(DIRECTED_ROWS[i].b);
        end

        for (int p = 0; p < SETTING_COUNT; p++)
        begin
            stop_sending();
            write_max_payload(settings[p]);
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
            begin
                // Stall the result side long enough for the input to back up.
                if (p == 1 && !hold_asked && items_sent >= PHASE_ITEMS / 4)
                begin
                    long_hold_req = 1'b1;
                    hold_asked = 1'b1;
                end
                send_random_frame();
            end
        end

        stop_sending();
        wait_for_drain();
        if (failures == 0 && pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
